// ----- src/bupq_pkg.sv -----
package bupq_pkg;

  // Sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ADDR_W          = 16;
  localparam int VAL_W           = 8;
  localparam int LIMIT_W         = 16;
  localparam int KIND_W          = 3;
  localparam int BYTE_W          = 8;
  localparam int QUEUED_W        = 5;
  localparam int MODE_W          = 2;
  localparam int STEP_W          = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd150;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_POST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPLOAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FRAME   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POSTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACKED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd5;

  // Frame bytes
  localparam logic [BYTE_W-1:0] BYTE_SYNC0 = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h7D;
  localparam logic [BYTE_W-1:0] BYTE_HEAD  = 8'h7E;
  localparam logic [BYTE_W-1:0] BYTE_FULL  = 8'h7F;

  // Sequencing types
  localparam logic [1:0] SEQ_NEXT = 2'd0;
  localparam logic [1:0] SEQ_JUMP = 2'd1;
  localparam logic [1:0] SEQ_COND = 2'd2;

  // Branch conditions
  localparam logic [2:0] COND_NONE  = 3'd0;
  localparam logic [2:0] COND_FULL  = 3'd1;
  localparam logic [2:0] COND_EMPTY = 3'd2;
  localparam logic [2:0] COND_MORE  = 3'd3;
  localparam logic [2:0] COND_LATCH = 3'd4;
  localparam logic [2:0] COND_AWAIT = 3'd5;
  localparam logic [2:0] COND_IDLEW = 3'd6;
  localparam logic [2:0] COND_LATE  = 3'd7;

  // Output byte sources
  localparam logic [2:0] BSEL_CONST = 3'd0;
  localparam logic [2:0] BSEL_COUNT = 3'd1;
  localparam logic [2:0] BSEL_AHI   = 3'd2;
  localparam logic [2:0] BSEL_ALO   = 3'd3;
  localparam logic [2:0] BSEL_VAL   = 3'd4;

  // Register ops
  localparam logic [1:0] OP_KEEP = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;  // flag set, ticks load one
  localparam logic [1:0] OP_CLR  = 2'd2;
  localparam logic [1:0] OP_INC  = 2'd3;

  // Program steps
  localparam logic [STEP_W-1:0] S_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] S_P0   = 5'd1;
  localparam logic [STEP_W-1:0] S_P1   = 5'd2;
  localparam logic [STEP_W-1:0] S_P2   = 5'd3;
  localparam logic [STEP_W-1:0] S_PF0  = 5'd4;
  localparam logic [STEP_W-1:0] S_PF1  = 5'd5;
  localparam logic [STEP_W-1:0] S_PF2  = 5'd6;
  localparam logic [STEP_W-1:0] S_U0   = 5'd7;
  localparam logic [STEP_W-1:0] S_U1   = 5'd8;
  localparam logic [STEP_W-1:0] S_U2   = 5'd9;
  localparam logic [STEP_W-1:0] S_U3   = 5'd10;
  localparam logic [STEP_W-1:0] S_U4   = 5'd11;
  localparam logic [STEP_W-1:0] S_U5   = 5'd12;
  localparam logic [STEP_W-1:0] S_U6   = 5'd13;
  localparam logic [STEP_W-1:0] S_U7   = 5'd14;
  localparam logic [STEP_W-1:0] S_U8   = 5'd15;
  localparam logic [STEP_W-1:0] S_U9   = 5'd16;
  localparam logic [STEP_W-1:0] S_U10  = 5'd17;
  localparam logic [STEP_W-1:0] S_AK0  = 5'd18;
  localparam logic [STEP_W-1:0] S_AK1  = 5'd19;
  localparam logic [STEP_W-1:0] S_UE   = 5'd20;
  localparam logic [STEP_W-1:0] S_A0   = 5'd21;
  localparam logic [STEP_W-1:0] S_A1   = 5'd22;
  localparam logic [STEP_W-1:0] S_T0   = 5'd23;
  localparam logic [STEP_W-1:0] S_T1   = 5'd24;
  localparam logic [STEP_W-1:0] S_T2   = 5'd25;
  localparam logic [STEP_W-1:0] S_TO0  = 5'd26;
  localparam logic [STEP_W-1:0] S_TO1  = 5'd27;

  // One control word
  typedef struct packed {
    logic [1:0]        seq;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [2:0]        bsel;
    logic [BYTE_W-1:0] cbyte;
    logic              last;
    logic              last_cond;  // last on final node unless ack latched
    logic [1:0]        cnt_op;
    logic              mem_we;
    logic [1:0]        ptr_op;
    logic [1:0]        await_op;
    logic [1:0]        latch_op;
    logic [1:0]        tick_op;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic full;
    logic empty;
    logic more;
    logic latch;
    logic await;
    logic late;
  } status_t;

  // Entry step for each mode
  function automatic logic [STEP_W-1:0] entry_step(input logic [MODE_W-1:0] mode);
    logic [STEP_W-1:0] s;
    case (mode)
      MODE_POST:   s = S_P0;
      MODE_UPLOAD: s = S_U0;
      MODE_ACK:    s = S_A0;
      MODE_TICK:   s = S_T0;
      default:     s = S_IDLE;
    endcase
    return s;
  endfunction

  // Microprogram
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      // post
      S_P0: begin
        w.seq = SEQ_COND; w.cond = COND_FULL; w.target = S_PF0;
      end
      S_P1: begin
        w.mem_we = 1'b1; w.cnt_op = OP_INC;
      end
      S_P2: begin
        w.emit = 1'b1; w.kind = KIND_POSTED; w.last = 1'b1;
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      S_PF0: begin
        w.cnt_op = OP_CLR;
      end
      S_PF1: begin
        w.emit = 1'b1; w.kind = KIND_FULL; w.cbyte = BYTE_ESC;
      end
      S_PF2: begin
        w.emit = 1'b1; w.kind = KIND_FULL; w.cbyte = BYTE_FULL; w.last = 1'b1;
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      // upload
      S_U0: begin
        w.seq = SEQ_COND; w.cond = COND_EMPTY; w.target = S_UE; w.ptr_op = OP_CLR;
      end
      S_U1: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.cbyte = BYTE_SYNC0;
      end
      S_U2: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.cbyte = BYTE_ESC;
      end
      S_U3: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.cbyte = BYTE_HEAD;
      end
      S_U4: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.bsel = BSEL_COUNT;
      end
      S_U5: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.bsel = BSEL_AHI;
      end
      S_U6: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.bsel = BSEL_ALO;
      end
      S_U7: begin
        w.emit = 1'b1; w.kind = KIND_FRAME; w.bsel = BSEL_VAL;
        w.last_cond = 1'b1; w.ptr_op = OP_INC;
      end
      S_U8: begin
        w.seq = SEQ_COND; w.cond = COND_MORE; w.target = S_U5;
      end
      S_U9: begin
        w.seq = SEQ_COND; w.cond = COND_LATCH; w.target = S_AK0;
      end
      S_U10: begin
        w.await_op = OP_SET; w.tick_op = OP_SET;
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      // acknowledged: drop the store
      S_AK0: begin
        w.latch_op = OP_CLR; w.await_op = OP_CLR; w.tick_op = OP_CLR;
        w.cnt_op = OP_CLR;
      end
      S_AK1: begin
        w.emit = 1'b1; w.kind = KIND_ACKED; w.last = 1'b1;
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      S_UE: begin
        w.emit = 1'b1; w.kind = KIND_EMPTY; w.last = 1'b1;
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      // acknowledge
      S_A0: begin
        w.seq = SEQ_COND; w.cond = COND_AWAIT; w.target = S_AK0;
      end
      S_A1: begin
        w.latch_op = OP_SET; w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      // tick
      S_T0: begin
        w.seq = SEQ_COND; w.cond = COND_IDLEW; w.target = S_IDLE;
      end
      S_T1: begin
        w.seq = SEQ_COND; w.cond = COND_LATE; w.target = S_TO0;
      end
      S_T2: begin
        w.tick_op = OP_INC; w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      S_TO0: begin
        w.await_op = OP_CLR; w.latch_op = OP_CLR; w.tick_op = OP_CLR;
      end
      S_TO1: begin
        w.emit = 1'b1; w.kind = KIND_TIMEOUT; w.last = 1'b1;
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
      default: begin
        w.seq = SEQ_JUMP; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/batch_upload_queue_with_ack_top.sv -----
// Post: steps P0 to P2 after the accept, or P0 and PF0 to PF2 when the store is full.
//   Upload: header, a loop per node, an ACKED result with a latched ack, EMPTY when empty;
//   frame bytes stream one per cycle in the header, then three per node with a loop test gap.
// Acknowledge latches or drops the store; tick counts or times out. Each result holds out_valid
//   for one cycle; the receiver cannot stall, so the output side never holds the sequencer.
// Sync active-low reset clears count, flags and tick counter, sets the limit to 150; store kept.
module batch_upload_queue_with_ack_top #(
  parameter int QUEUE_DEPTH = bupq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bupq_pkg::MODE_W-1:0]         in_mode,
  input  logic [bupq_pkg::ADDR_W-1:0]         in_node_address,
  input  logic [bupq_pkg::VAL_W-1:0]          in_node_value,
  input  logic                                cfg_wr_en,
  input  logic [bupq_pkg::LIMIT_W-1:0]        cfg_wr_data,
  output logic                                out_valid,
  output logic [bupq_pkg::KIND_W-1:0]         out_kind,
  output logic [bupq_pkg::BYTE_W-1:0]         out_byte,
  output logic [bupq_pkg::QUEUED_W-1:0]       out_queued,
  output logic                                out_last
);

  logic              accept;
  bupq_pkg::ctrl_t   ctrl;
  bupq_pkg::status_t status;

  // Input transfer
  assign accept = start & ~busy;

  bupq_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .mode   (in_mode),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  bupq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .node_address (in_node_address),
    .node_value   (in_node_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .ctrl         (ctrl),
    .status       (status),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_queued   (out_queued),
    .out_last     (out_last)
  );

endmodule

// ----- src/bupq_seq.sv -----
module bupq_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [bupq_pkg::MODE_W-1:0]     mode,
  input  bupq_pkg::status_t               status,
  output bupq_pkg::ctrl_t                 ctrl,
  output logic                            busy
);

  logic [bupq_pkg::STEP_W-1:0] step_r;
  logic [bupq_pkg::STEP_W-1:0] step_nxt;
  logic                        cond_hit;

  // Control word for the current step
  assign ctrl = bupq_pkg::rom_word(step_r);
  assign busy = (step_r != bupq_pkg::S_IDLE);

  // Branch condition select
  always_comb begin
    case (ctrl.cond)
      bupq_pkg::COND_FULL:  cond_hit = status.full;
      bupq_pkg::COND_EMPTY: cond_hit = status.empty;
      bupq_pkg::COND_MORE:  cond_hit = status.more;
      bupq_pkg::COND_LATCH: cond_hit = status.latch;
      bupq_pkg::COND_AWAIT: cond_hit = status.await;
      bupq_pkg::COND_IDLEW: cond_hit = ~status.await;
      bupq_pkg::COND_LATE:  cond_hit = status.late;
      default:              cond_hit = 1'b0;
    endcase
  end

  // Next step: dispatch from idle, else follow the word
  always_comb begin
    step_nxt = step_r;
    if (step_r == bupq_pkg::S_IDLE) begin
      if (accept) begin
        step_nxt = bupq_pkg::entry_step(mode);
      end
    end else begin
      case (ctrl.seq)
        bupq_pkg::SEQ_JUMP: step_nxt = ctrl.target;
        bupq_pkg::SEQ_COND: step_nxt = cond_hit ? ctrl.target
                                                : step_r + bupq_pkg::STEP_W'(1);
        default:            step_nxt = step_r + bupq_pkg::STEP_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bupq_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- src/bupq_dp.sv -----
module bupq_dp #(
  parameter int QUEUE_DEPTH = bupq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [bupq_pkg::ADDR_W-1:0]       node_address,
  input  logic [bupq_pkg::VAL_W-1:0]        node_value,
  input  logic                              cfg_wr_en,
  input  logic [bupq_pkg::LIMIT_W-1:0]      cfg_wr_data,
  input  bupq_pkg::ctrl_t                   ctrl,
  output bupq_pkg::status_t                 status,
  output logic                              out_valid,
  output logic [bupq_pkg::KIND_W-1:0]       out_kind,
  output logic [bupq_pkg::BYTE_W-1:0]       out_byte,
  output logic [bupq_pkg::QUEUED_W-1:0]     out_queued,
  output logic                              out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // Node store
  logic [bupq_pkg::ADDR_W-1:0] addr_mem [QUEUE_DEPTH];
  logic [bupq_pkg::VAL_W-1:0]  val_mem  [QUEUE_DEPTH];
  logic [bupq_pkg::ADDR_W-1:0] rd_addr_r;
  logic [bupq_pkg::VAL_W-1:0]  rd_val_r;

  // Held input payload
  logic [bupq_pkg::ADDR_W-1:0] in_addr_r;
  logic [bupq_pkg::VAL_W-1:0]  in_val_r;

  logic [CNT_W-1:0]             count_r,  count_nxt;
  logic [CNT_W-1:0]             ptr_r,    ptr_nxt;
  logic                         await_r,  await_nxt;
  logic                         latch_r,  latch_nxt;
  logic [bupq_pkg::LIMIT_W-1:0] ticks_r,  ticks_nxt;
  logic [bupq_pkg::LIMIT_W-1:0] limit_r;
  logic                         ptr_last;
  logic [bupq_pkg::BYTE_W-1:0]  byte_sel;

  logic                         out_valid_r;
  logic [bupq_pkg::KIND_W-1:0]  out_kind_r;
  logic [bupq_pkg::BYTE_W-1:0]  out_byte_r;
  logic [bupq_pkg::QUEUED_W-1:0] out_queued_r;
  logic                         out_last_r;

  // Status flags for branching
  assign ptr_last      = ((ptr_r + CNT_W'(1)) == count_r);
  assign status.full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty  = (count_r == '0);
  assign status.more   = (ptr_r != count_r);
  assign status.latch  = latch_r;
  assign status.await  = await_r;
  assign status.late   = (ticks_r > limit_r);

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_addr_r <= node_address;
      in_val_r  <= node_value;
    end
  end

  // Store write at the fill position, registered read at the upload pointer
  always_ff @(posedge clk) begin
    if (ctrl.mem_we) begin
      addr_mem[count_r[IDX_W-1:0]] <= in_addr_r;
      val_mem[count_r[IDX_W-1:0]]  <= in_val_r;
    end
    if (ptr_r < CNT_W'(QUEUE_DEPTH)) begin
      rd_addr_r <= addr_mem[ptr_r[IDX_W-1:0]];
      rd_val_r  <= val_mem[ptr_r[IDX_W-1:0]];
    end
  end

  // Register ops from the control word
  always_comb begin
    case (ctrl.cnt_op)
      bupq_pkg::OP_INC: count_nxt = count_r + CNT_W'(1);
      bupq_pkg::OP_CLR: count_nxt = '0;
      default:          count_nxt = count_r;
    endcase
    case (ctrl.ptr_op)
      bupq_pkg::OP_INC: ptr_nxt = ptr_r + CNT_W'(1);
      bupq_pkg::OP_CLR: ptr_nxt = '0;
      default:          ptr_nxt = ptr_r;
    endcase
    case (ctrl.await_op)
      bupq_pkg::OP_SET: await_nxt = 1'b1;
      bupq_pkg::OP_CLR: await_nxt = 1'b0;
      default:          await_nxt = await_r;
    endcase
    case (ctrl.latch_op)
      bupq_pkg::OP_SET: latch_nxt = 1'b1;
      bupq_pkg::OP_CLR: latch_nxt = 1'b0;
      default:          latch_nxt = latch_r;
    endcase
    case (ctrl.tick_op)
      bupq_pkg::OP_SET: ticks_nxt = bupq_pkg::LIMIT_W'(1);
      bupq_pkg::OP_CLR: ticks_nxt = '0;
      bupq_pkg::OP_INC: ticks_nxt = ticks_r + bupq_pkg::LIMIT_W'(1);
      default:          ticks_nxt = ticks_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      await_r <= 1'b0;
      latch_r <= 1'b0;
      ticks_r <= '0;
      limit_r <= bupq_pkg::LIMIT_RESET;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      await_r <= await_nxt;
      latch_r <= latch_nxt;
      ticks_r <= ticks_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Output byte source
  always_comb begin
    case (ctrl.bsel)
      bupq_pkg::BSEL_COUNT: byte_sel = bupq_pkg::BYTE_W'(count_r);
      bupq_pkg::BSEL_AHI:   byte_sel = rd_addr_r[15:8];
      bupq_pkg::BSEL_ALO:   byte_sel = rd_addr_r[7:0];
      bupq_pkg::BSEL_VAL:   byte_sel = rd_val_r;
      default:              byte_sel = ctrl.cbyte;
    endcase
  end

  // Result register: one transfer per emitting step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_kind_r   <= ctrl.kind;
      out_byte_r   <= byte_sel;
      out_queued_r <= bupq_pkg::QUEUED_W'(count_r);
      out_last_r   <= ctrl.last | (ctrl.last_cond & ptr_last & ~latch_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_queued = out_queued_r;
  assign out_last   = out_last_r;

endmodule
